>>> hdl/datt_pkg.sv
// shared types and constants for the delivery ack timeout tracker
`default_nettype none

package datt_pkg;

    localparam int SEQ_W = 32;
    localparam int TIME_W = 32;
    localparam int KIND_W = 2;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

    localparam logic [KIND_W-1:0] KIND_SENT      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELIVERED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOST      = 2'd2;

    typedef enum logic [1:0] {
        OP_SEND  = 2'd0,
        OP_ACK   = 2'd1,
        OP_TICK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // command word passed from front end to back end
    typedef struct packed {
        op_t               op;
        logic [SEQ_W-1:0]  value;
        logic [TIME_W-1:0] stamp;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

>>> hdl/datt_front.sv
// front end: accepts words, assigns sequence numbers and tick stamps
`default_nettype none

module datt_front
    import datt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       mode,
    input  wire logic [SEQ_W-1:0] ack_seq,
    input  wire q_status_t        q_status,
    output logic                  busy,
    output logic                  push,
    output cmd_t                  push_cmd
);

    logic [SEQ_W-1:0]  next_seq_reg;
    logic [SEQ_W-1:0]  next_seq_next;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] now_next;
    op_t               op;

    assign busy = q_status.full;
    assign push = start && !q_status.full;
    assign op   = op_t'(mode);

    always_comb
    begin
        next_seq_next  = next_seq_reg;
        now_next       = now_reg;
        push_cmd.op    = op;
        push_cmd.value = ack_seq;
        push_cmd.stamp = now_reg;
        case (op)
            OP_SEND:
            begin
                push_cmd.value = next_seq_reg;
                if (push)
                begin
                    next_seq_next = next_seq_reg + 1'b1;
                end
            end
            OP_TICK:
            begin
                push_cmd.stamp = now_reg + 1'b1;
                if (push)
                begin
                    now_next = now_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_seq_reg <= '0;
            now_reg      <= '0;
        end
        else
        begin
            next_seq_reg <= next_seq_next;
            now_reg      <= now_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/datt_queue.sv
// two-entry command queue between front end and back end
`default_nettype none

module datt_queue
    import datt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output q_status_t status
);

    cmd_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_cmd      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !status.full)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !status.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> hdl/datt_back.sv
// back end: pending table, parallel match and result sequencing
`default_nettype none

module datt_back
    import datt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              timeout_we,
    input  wire logic [TIME_W-1:0] timeout_wdata,
    input  wire q_status_t         q_status,
    input  wire cmd_t              cmd,
    output logic                   pop,
    output logic                   result_valid,
    output logic [KIND_W-1:0]      event_kind,
    output logic [SEQ_W-1:0]       seq_number,
    output logic                   table_full,
    output logic                   last
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                  state_reg, state_next;
    logic [TABLE_DEPTH-1:0]  valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0]  hit_reg, hit_next;
    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic                    res_valid_reg, res_valid_next;
    logic [KIND_W-1:0]       res_kind_reg, res_kind_next;
    logic [SEQ_W-1:0]        res_seq_reg, res_seq_next;
    logic                    res_full_reg, res_full_next;
    logic                    res_last_reg, res_last_next;
    logic [TIME_W-1:0]       timeout_reg;

    logic [SEQ_W-1:0]        seq_mem  [TABLE_DEPTH];
    logic [TIME_W-1:0]       time_mem [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0]  free_vec;
    logic [TABLE_DEPTH-1:0]  ack_hit;
    logic [TABLE_DEPTH-1:0]  age_hit;
    logic [TABLE_DEPTH-1:0]  hit_low;
    logic [TABLE_DEPTH-1:0]  hit_rest;
    logic [IDX_W-1:0]        free_idx;
    logic [IDX_W-1:0]        hit_idx;
    logic                    wr_en;

    assign result_valid = res_valid_reg;
    assign event_kind   = res_kind_reg;
    assign seq_number   = res_seq_reg;
    assign table_full   = res_full_reg;
    assign last         = res_last_reg;

    assign free_vec = ~valid_reg;
    assign hit_low  = hit_reg & (~hit_reg + 1'b1);
    assign hit_rest = hit_reg & ~hit_low;

    // parallel match over all entries
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            ack_hit[i] = valid_reg[i] && (seq_mem[i] == cmd.value);
            age_hit[i] = valid_reg[i] && ((cmd.stamp - time_mem[i]) > timeout_reg);
        end
    end

    // lowest free slot and lowest pending hit
    always_comb
    begin
        free_idx = '0;
        hit_idx  = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                free_idx = IDX_W'(i);
            end
            if (hit_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        hit_next       = hit_reg;
        kind_next      = kind_reg;
        res_valid_next = 1'b0;
        res_kind_next  = res_kind_reg;
        res_seq_next   = res_seq_reg;
        res_full_next  = 1'b0;
        res_last_next  = 1'b0;
        pop            = 1'b0;
        wr_en          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    case (cmd.op)
                        OP_SEND:
                        begin
                            res_valid_next = 1'b1;
                            res_kind_next  = KIND_SENT;
                            res_seq_next   = cmd.value;
                            res_full_next  = ~|free_vec;
                            res_last_next  = 1'b1;
                            if (|free_vec)
                            begin
                                wr_en                = 1'b1;
                                valid_next[free_idx] = 1'b1;
                            end
                        end
                        OP_ACK:
                        begin
                            valid_next = valid_reg & ~ack_hit;
                            hit_next   = ack_hit;
                            kind_next  = KIND_DELIVERED;
                            if (|ack_hit)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_TICK:
                        begin
                            valid_next = valid_reg & ~age_hit;
                            hit_next   = age_hit;
                            kind_next  = KIND_LOST;
                            if (|age_hit)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                res_valid_next = 1'b1;
                res_kind_next  = kind_reg;
                res_seq_next   = seq_mem[hit_idx];
                res_last_next  = ~|hit_rest;
                hit_next       = hit_rest;
                if (~|hit_rest)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seq_mem[free_idx]  <= cmd.value;
            time_mem[free_idx] <= cmd.stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (timeout_we)
        begin
            timeout_reg <= timeout_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            hit_reg       <= '0;
            kind_reg      <= KIND_SENT;
            res_valid_reg <= 1'b0;
            res_kind_reg  <= KIND_SENT;
            res_seq_reg   <= '0;
            res_full_reg  <= 1'b0;
            res_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            hit_reg       <= hit_next;
            kind_reg      <= kind_next;
            res_valid_reg <= res_valid_next;
            res_kind_reg  <= res_kind_next;
            res_seq_reg   <= res_seq_next;
            res_full_reg  <= res_full_next;
            res_last_reg  <= res_last_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (hit_reg != '0))
        else $error("scan with no pending hit");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((hit_reg & valid_reg) == '0))
        else $error("reported entry still valid");
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> result_valid)
        else $error("gap inside result burst");
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (event_kind != KIND_SENT)) |-> !table_full)
        else $error("full flag on non-send word");

endmodule

`default_nettype wire

>>> hdl/delivery_ack_timeout_tracker.sv
// top level of the delivery ack timeout tracker
// A word is taken when start is high and busy is low; busy rises only while the two-entry
// command queue is full. The front end stamps every word as it is taken. In the back end a
// send or clear is handled in the idle state; an ack or tick does the parallel match over
// all table entries in the idle state, then reports each delivered or lost entry in the
// scan state, with at most TABLE_DEPTH reports. Results come one per cycle from an output
// register, each marked by result_valid for a single cycle, last high on the final word of
// each command; the receiver cannot hold them off. An ack or tick that removes nothing
// gives no result. The timeout register is written through timeout_we and timeout_wdata.
`default_nettype none

module delivery_ack_timeout_tracker
    import datt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        mode,
    input  wire logic [SEQ_W-1:0]  ack_seq,
    input  wire logic              timeout_we,
    input  wire logic [TIME_W-1:0] timeout_wdata,
    output logic                   result_valid,
    output logic [KIND_W-1:0]      event_kind,
    output logic [SEQ_W-1:0]       seq_number,
    output logic                   table_full,
    output logic                   last
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      pop_cmd;

    datt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .mode     (mode),
        .ack_seq  (ack_seq),
        .q_status (q_status),
        .busy     (busy),
        .push     (push),
        .push_cmd (push_cmd)
    );

    datt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    datt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_we    (timeout_we),
        .timeout_wdata (timeout_wdata),
        .q_status      (q_status),
        .cmd           (pop_cmd),
        .pop           (pop),
        .result_valid  (result_valid),
        .event_kind    (event_kind),
        .seq_number    (seq_number),
        .table_full    (table_full),
        .last          (last)
    );

endmodule

`default_nettype wire

>>> dv/delivery_ack_timeout_tracker_test.sv
// self-checking testbench for the delivery ack timeout tracker
`timescale 1ns / 1ps

module delivery_ack_timeout_tracker_test;
    import datt_pkg::*;

    localparam int DEPTH = 32;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT = 5000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq;
        logic              full;
        logic              last;
    } tracker_event_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        mode;
    logic [SEQ_W-1:0]  ack_seq;
    logic              timeout_we;
    logic [TIME_W-1:0] timeout_wdata;
    logic              result_valid;
    logic [KIND_W-1:0] event_kind;
    logic [SEQ_W-1:0]  seq_number;
    logic              table_full;
    logic              last;

    // tracker state as predicted
    logic              slot_valid [DEPTH];
    logic [SEQ_W-1:0]  slot_seq [DEPTH];
    logic [TIME_W-1:0] slot_sent [DEPTH];
    logic [SEQ_W-1:0]  next_seq_pred;
    logic [TIME_W-1:0] now_pred;
    logic [TIME_W-1:0] timeout_pred;

    tracker_event_t expected_events [$];
    tracker_event_t head_event;
    int             error_count = 0;
    int             max_gap = 5;
    int             cycle_count = 0;

    delivery_ack_timeout_tracker #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .ack_seq(ack_seq),
        .timeout_we(timeout_we),
        .timeout_wdata(timeout_wdata),
        .result_valid(result_valid),
        .event_kind(event_kind),
        .seq_number(seq_number),
        .table_full(table_full),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [SEQ_W-1:0] got,
                                   input logic [SEQ_W-1:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic reset_prediction();
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_seq[i] = '0;
            slot_sent[i] = '0;
        end
        next_seq_pred = '0;
        now_pred = '0;
        timeout_pred = TIMEOUT_RESET;
    endtask

    task automatic predict_word(input op_t op, input logic [SEQ_W-1:0] ack);
        logic [DEPTH-1:0] hit;
        tracker_event_t   ev;
        logic             stored;
        hit = '0;
        stored = 1'b0;
        case (op)
            OP_SEND:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (!stored && !slot_valid[i])
                    begin
                        slot_valid[i] = 1'b1;
                        slot_seq[i] = next_seq_pred;
                        slot_sent[i] = now_pred;
                        stored = 1'b1;
                    end
                end
                ev.kind = KIND_SENT;
                ev.seq = next_seq_pred;
                ev.full = !stored;
                ev.last = 1'b1;
                expected_events.insert(expected_events.size(), ev);
                next_seq_pred = next_seq_pred + 1'b1;
            end
            OP_ACK:
            begin
                for (int i = 0; i < DEPTH; i++)
                    hit[i] = slot_valid[i] && (slot_seq[i] == ack);
            end
            OP_TICK:
            begin
                now_pred = now_pred + 1'b1;
                for (int i = 0; i < DEPTH; i++)
                    hit[i] = slot_valid[i] && ((now_pred - slot_sent[i]) > timeout_pred);
            end
            default:
            begin
                for (int i = 0; i < DEPTH; i++)
                    slot_valid[i] = 1'b0;
            end
        endcase
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit[i])
            begin
                slot_valid[i] = 1'b0;
                ev.kind = (op == OP_ACK) ? KIND_DELIVERED : KIND_LOST;
                ev.seq = slot_seq[i];
                ev.full = 1'b0;
                ev.last = ((hit >> (i + 1)) == '0);
                expected_events.insert(expected_events.size(), ev);
            end
        end
    endtask

    task automatic send_word(input op_t op, input logic [SEQ_W-1:0] ack);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        mode <= op;
        ack_seq <= ack;
        do @(posedge clk); while (busy !== 1'b0);
        predict_word(op, ack);
    endtask

    // hold off until every expected word has come (or the drain limit is reached) and the block has gone quiet
    task automatic settle_idle();
        int waited;
        waited = 0;
        @(negedge clk);
        start <= 1'b0;
        while (expected_events.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TIME_W-1:0] value);
        settle_idle();
        @(negedge clk);
        timeout_we <= 1'b1;
        timeout_wdata <= value;
        @(negedge clk);
        timeout_we <= 1'b0;
        timeout_pred = value;
    endtask

    function automatic logic [SEQ_W-1:0] pick_ack();
        int r;
        int base;
        int idx;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            base = $urandom_range(0, DEPTH - 1);
            for (int k = 0; k < DEPTH; k++)
            begin
                idx = (base + k) % DEPTH;
                if (slot_valid[idx])
                    return slot_seq[idx];
            end
        end
        if (r < 8)
            return next_seq_pred - $urandom_range(0, 4);
        return $urandom();
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
        begin
            if (expected_events.size() == 0)
                report_mismatch("word with nothing expected, seq", seq_number, '0);
            else
            begin
                head_event = expected_events.pop_front();
                if (event_kind !== head_event.kind)
                    report_mismatch("event_kind", SEQ_W'(event_kind),
                                    SEQ_W'(head_event.kind));
                if (seq_number !== head_event.seq)
                    report_mismatch("seq_number", seq_number, head_event.seq);
                if (table_full !== head_event.full)
                    report_mismatch("table_full", SEQ_W'(table_full),
                                    SEQ_W'(head_event.full));
                if (last !== head_event.last)
                    report_mismatch("last", SEQ_W'(last), SEQ_W'(head_event.last));
            end
        end
    end

    task automatic test_send_and_ack();
        send_word(OP_SEND, 32'hFFFF_FFFF);
        send_word(OP_SEND, '0);
        send_word(OP_SEND, $urandom());
        send_word(OP_ACK, 32'd1);
        send_word(OP_ACK, 32'd0);
        send_word(OP_ACK, 32'hFFFF_FFFF);
        send_word(OP_ACK, 32'd0);
        send_word(OP_ACK, 32'd2);
    endtask

    task automatic test_timeout_extremes();
        write_timeout(32'd1);
        send_word(OP_CLEAR, '0);
        send_word(OP_SEND, '0);
        send_word(OP_SEND, '0);
        send_word(OP_TICK, '0);
        send_word(OP_TICK, '0);
        write_timeout(32'd0);
        send_word(OP_SEND, '0);
        send_word(OP_TICK, '0);
        send_word(OP_TICK, '0);
        write_timeout(32'hFFFF_FFFF);
        send_word(OP_SEND, '0);
        send_word(OP_TICK, '0);
        send_word(OP_TICK, '0);
        send_word(OP_CLEAR, '0);
    endtask

    task automatic test_clear_keeps_counters();
        write_timeout(32'd2);
        send_word(OP_SEND, '0);
        send_word(OP_CLEAR, '0);
        send_word(OP_ACK, next_seq_pred - 1'b1);
        send_word(OP_TICK, '0);
        send_word(OP_TICK, '0);
        send_word(OP_TICK, '0);
        send_word(OP_SEND, '0);
        send_word(OP_ACK, next_seq_pred - 1'b1);
    endtask

    task automatic test_table_full();
        write_timeout(32'hFFFF_FFFF);
        send_word(OP_CLEAR, '0);
        for (int i = 0; i < DEPTH + 2; i++)
            send_word(OP_SEND, $urandom());
        send_word(OP_ACK, next_seq_pred - 32'd10);
        send_word(OP_SEND, '0);
        send_word(OP_SEND, '0);
        send_word(OP_CLEAR, '0);
    endtask

    task automatic test_random_traffic();
        logic [TIME_W-1:0] timeout_value;
        int                r;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: timeout_value = 32'd1;
                1: timeout_value = $urandom_range(2, 12);
                2: timeout_value = 32'hFFFF_FFFF;
                3: timeout_value = $urandom_range(3, 30);
                4: timeout_value = $urandom();
                default: timeout_value = 32'd5;
            endcase
            write_timeout(timeout_value);
            max_gap = (phase % 3 == 2) ? 0 : 5;
            for (int n = 0; n < 55; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    send_word(OP_SEND, $urandom());
                else if (r < 70)
                    send_word(OP_ACK, pick_ack());
                else if (r < 95)
                    send_word(OP_TICK, $urandom());
                else
                    send_word(OP_CLEAR, $urandom());
            end
        end
        max_gap = 5;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = OP_SEND;
        ack_seq = '0;
        timeout_we = 1'b0;
        timeout_wdata = '0;
        reset_prediction();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_send_and_ack();
        test_timeout_extremes();
        test_clear_keeps_counters();
        test_table_full();
        test_random_traffic();

        settle_idle();
        if (expected_events.size() != 0)
            report_mismatch("words still expected", SEQ_W'(expected_events.size()), '0);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
hdl/datt_pkg.sv
hdl/datt_front.sv
hdl/datt_queue.sv
hdl/datt_back.sv
hdl/delivery_ack_timeout_tracker.sv
dv/delivery_ack_timeout_tracker_test.sv
